FILE: design/ptc_pkg.sv
package ptc_pkg;

    // Field and register widths
    localparam int ANGLE_W    = 23;
    localparam int ERR_W      = 24;
    localparam int DERIV_W    = 25;
    localparam int GAIN_W     = 20;
    localparam int WIN_W      = 22;
    localparam int LIMIT_W    = 12;
    localparam int TOL_W      = 16;
    localparam int STEP_W     = 16;
    localparam int SUM_W      = 32;
    localparam int DRIVE_W    = 13;
    localparam int ACC_W      = 56;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 23;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P           = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I           = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D           = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_WINDOW  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TOLERANCE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_CAP    = 4'd7;

    // Register values after reset
    localparam logic [ANGLE_W-1:0] RST_TARGET_ANGLE     = 23'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P           = 20'd9830;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I           = 20'd590;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D           = 20'd66;
    localparam logic [WIN_W-1:0]   RST_INTEGRAL_WINDOW  = 22'd4096;
    localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT      = 12'd2048;
    localparam logic [TOL_W-1:0]   RST_SETTLE_TOLERANCE = 16'd128;
    localparam logic [STEP_W-1:0]  RST_ITERATION_CAP    = 16'd700;

    // Rounding offset: one half in the Q.16 accumulator
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 56'sd32768;

endpackage

FILE: design/pid_turn_controller.sv
// Turn-to-heading PID controller. Each accepted heading sample yields one result by way
// of the input register, then the result register, and a new sample can be taken
// in every cycle while the result side keeps up: the whole control step (error,
// settle test, windowed saturating integral, three gain multiplies, round and clamp)
// is one combinational pass between the two registers, which sets the clock limit.
// Once settled or out of iterations the block reports done with zero drive until a
// sample arrives with restart set. Configuration is written through the cfg channel,
// which is always ready; writes to an index beyond the register list are dropped.
module pid_turn_controller (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [ptc_pkg::ANGLE_W-1:0]     i_heading,
    input  logic                                   i_restart,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [ptc_pkg::DRIVE_W-1:0]     o_left_drive,
    output logic signed [ptc_pkg::DRIVE_W-1:0]     o_right_drive,
    output logic                                   o_done_res,
    output logic signed [ptc_pkg::ERR_W-1:0]       o_heading_error,
    output logic        [ptc_pkg::STEP_W-1:0]      o_steps_taken,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [ptc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [ptc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic signed [ptc_pkg::ANGLE_W-1:0] r_target;
    logic        [ptc_pkg::GAIN_W-1:0]  r_gain_p;
    logic        [ptc_pkg::GAIN_W-1:0]  r_gain_i;
    logic        [ptc_pkg::GAIN_W-1:0]  r_gain_d;
    logic        [ptc_pkg::WIN_W-1:0]   r_window;
    logic        [ptc_pkg::LIMIT_W-1:0] r_limit;
    logic        [ptc_pkg::TOL_W-1:0]   r_tol;
    logic        [ptc_pkg::STEP_W-1:0]  r_cap;

    // Controller state
    logic signed [ptc_pkg::ERR_W-1:0]   r_prev_err;
    logic signed [ptc_pkg::SUM_W-1:0]   r_sum;
    logic        [ptc_pkg::STEP_W-1:0]  r_step;
    logic                               r_settled;

    // Input register
    logic                               r_a_vld;
    logic signed [ptc_pkg::ANGLE_W-1:0] r_a_heading;
    logic                               r_a_restart;

    // Result register
    logic                               r_b_vld;
    logic signed [ptc_pkg::DRIVE_W-1:0] r_b_left;
    logic signed [ptc_pkg::DRIVE_W-1:0] r_b_right;
    logic                               r_b_done;
    logic signed [ptc_pkg::ERR_W-1:0]   r_b_err;
    logic        [ptc_pkg::STEP_W-1:0]  r_b_step;

    logic w_in_acc;
    logic w_adv_a;

    logic signed [ptc_pkg::ERR_W-1:0]          w_eff_prev;
    logic signed [ptc_pkg::SUM_W-1:0]          w_eff_sum;
    logic        [ptc_pkg::STEP_W-1:0]         w_eff_step;
    logic                                      w_eff_settled;
    logic signed [ptc_pkg::ERR_W-1:0]          w_err;
    logic        [ptc_pkg::ERR_W-1:0]          w_abs;
    logic                                      w_done;
    logic signed [ptc_pkg::DERIV_W-1:0]        w_deriv;
    logic                                      w_in_win;
    logic signed [ptc_pkg::SUM_W:0]            w_sum_ext;
    logic signed [ptc_pkg::SUM_W-1:0]          w_sum_sat;
    logic signed [ptc_pkg::SUM_W-1:0]          w_sum_new;
    logic signed [ptc_pkg::ERR_W+ptc_pkg::GAIN_W:0]   w_prod_p;
    logic signed [ptc_pkg::DERIV_W+ptc_pkg::GAIN_W:0] w_prod_d;
    logic signed [ptc_pkg::SUM_W+ptc_pkg::GAIN_W:0]   w_prod_i;
    logic signed [ptc_pkg::ACC_W-1:0]          w_acc;
    logic signed [ptc_pkg::ACC_W-ptc_pkg::FRAC_W-1:0] w_round;
    logic signed [ptc_pkg::ACC_W-ptc_pkg::FRAC_W-1:0] w_lim;
    logic signed [ptc_pkg::ACC_W-ptc_pkg::FRAC_W-1:0] w_clamp;
    logic signed [ptc_pkg::DRIVE_W-1:0]        w_drive;
    logic        [ptc_pkg::STEP_W-1:0]         w_step_new;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= ptc_pkg::RST_TARGET_ANGLE;
            r_gain_p <= ptc_pkg::RST_GAIN_P;
            r_gain_i <= ptc_pkg::RST_GAIN_I;
            r_gain_d <= ptc_pkg::RST_GAIN_D;
            r_window <= ptc_pkg::RST_INTEGRAL_WINDOW;
            r_limit  <= ptc_pkg::RST_DRIVE_LIMIT;
            r_tol    <= ptc_pkg::RST_SETTLE_TOLERANCE;
            r_cap    <= ptc_pkg::RST_ITERATION_CAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ptc_pkg::REG_TARGET_ANGLE:     r_target <= i_cfg_data[ptc_pkg::ANGLE_W-1:0];
                ptc_pkg::REG_GAIN_P:           r_gain_p <= i_cfg_data[ptc_pkg::GAIN_W-1:0];
                ptc_pkg::REG_GAIN_I:           r_gain_i <= i_cfg_data[ptc_pkg::GAIN_W-1:0];
                ptc_pkg::REG_GAIN_D:           r_gain_d <= i_cfg_data[ptc_pkg::GAIN_W-1:0];
                ptc_pkg::REG_INTEGRAL_WINDOW:  r_window <= i_cfg_data[ptc_pkg::WIN_W-1:0];
                ptc_pkg::REG_DRIVE_LIMIT:      r_limit  <= i_cfg_data[ptc_pkg::LIMIT_W-1:0];
                ptc_pkg::REG_SETTLE_TOLERANCE: r_tol    <= i_cfg_data[ptc_pkg::TOL_W-1:0];
                ptc_pkg::REG_ITERATION_CAP:    r_cap    <= i_cfg_data[ptc_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register is free
    assign w_adv_a    = r_a_vld && (!r_b_vld || !i_out_stall);
    assign o_in_stall = r_a_vld && !w_adv_a;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_a_vld <= 1'b1;
        end else if (w_adv_a) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_heading <= i_heading;
            r_a_restart <= i_restart;
        end
    end

    // Restart clears the history before this step is evaluated
    always_comb begin
        w_eff_prev    = r_a_restart ? '0 : r_prev_err;
        w_eff_sum     = r_a_restart ? '0 : r_sum;
        w_eff_step    = r_a_restart ? '0 : r_step;
        w_eff_settled = r_a_restart ? 1'b0 : r_settled;
    end

    always_comb begin
        w_err = $signed({r_target[ptc_pkg::ANGLE_W-1], r_target})
              - $signed({r_a_heading[ptc_pkg::ANGLE_W-1], r_a_heading});
        w_abs = w_err[ptc_pkg::ERR_W-1] ? ptc_pkg::ERR_W'(-w_err) : ptc_pkg::ERR_W'(w_err);

        w_done = w_eff_settled
              || (w_abs <= ptc_pkg::ERR_W'(r_tol))
              || (w_eff_step >= r_cap);

        w_deriv = $signed({w_err[ptc_pkg::ERR_W-1], w_err})
                - $signed({w_eff_prev[ptc_pkg::ERR_W-1], w_eff_prev});

        // Integral: accumulate inside the window, clear outside it, saturate at the 32-bit limits
        w_in_win  = (w_err != '0) && (w_abs < ptc_pkg::ERR_W'(r_window));
        w_sum_ext = (ptc_pkg::SUM_W+1)'(w_eff_sum) + (ptc_pkg::SUM_W+1)'(w_err);
        if (w_sum_ext[ptc_pkg::SUM_W] != w_sum_ext[ptc_pkg::SUM_W-1]) begin
            w_sum_sat = w_sum_ext[ptc_pkg::SUM_W]
                      ? {1'b1, {(ptc_pkg::SUM_W-1){1'b0}}}
                      : {1'b0, {(ptc_pkg::SUM_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_ext[ptc_pkg::SUM_W-1:0];
        end
        w_sum_new = w_in_win ? w_sum_sat : '0;

        w_prod_p = w_err     * $signed({1'b0, r_gain_p});
        w_prod_d = w_deriv   * $signed({1'b0, r_gain_d});
        w_prod_i = w_sum_new * $signed({1'b0, r_gain_i});

        // Round half up, then floor by arithmetic shift
        w_acc   = ptc_pkg::ACC_W'(w_prod_p) + ptc_pkg::ACC_W'(w_prod_d)
                + ptc_pkg::ACC_W'(w_prod_i) + ptc_pkg::ROUND_HALF;
        w_round = w_acc[ptc_pkg::ACC_W-1:ptc_pkg::FRAC_W];
        w_lim   = $signed({{(ptc_pkg::ACC_W-ptc_pkg::FRAC_W-ptc_pkg::LIMIT_W){1'b0}}, r_limit});

        if (w_round > w_lim) begin
            w_clamp = w_lim;
        end else if (w_round < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = w_round;
        end

        w_drive    = w_done ? '0 : w_clamp[ptc_pkg::DRIVE_W-1:0];
        w_step_new = w_done ? w_eff_step : w_eff_step + ptc_pkg::STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_sum      <= '0;
            r_step     <= '0;
            r_settled  <= 1'b0;
        end else if (w_adv_a) begin
            r_settled <= w_done;
            r_step    <= w_step_new;
            if (w_done) begin
                r_prev_err <= w_eff_prev;
                r_sum      <= w_eff_sum;
            end else begin
                r_prev_err <= w_err;
                r_sum      <= w_sum_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv_a) begin
            r_b_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_b_left  <= w_drive;
            r_b_right <= -w_drive;
            r_b_done  <= w_done;
            r_b_err   <= w_err;
            r_b_step  <= w_step_new;
        end
    end

    assign o_out_valid     = r_b_vld;
    assign o_left_drive    = r_b_left;
    assign o_right_drive   = r_b_right;
    assign o_done_res      = r_b_done;
    assign o_heading_error = r_b_err;
    assign o_steps_taken   = r_b_step;

endmodule

FILE: design/ptc_checker.sv
module ptc_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [ptc_pkg::DRIVE_W-1:0]     o_left_drive,
    input logic signed [ptc_pkg::DRIVE_W-1:0]     o_right_drive,
    input logic                                   o_done_res
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // Input side stalls only when both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_right_drive == -o_left_drive))
        else $error("right drive is not the negation of left drive");

    a_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_left_drive == '0))
        else $error("nonzero drive while done");

endmodule

bind pid_turn_controller ptc_checker u_ptc_checker (.*);
